>>> hw/rtl/fifo_with_waiter_handoff_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mailbox queue
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_WAITER_HANDOFF_MACROS_SVH
`define FIFO_WITH_WAITER_HANDOFF_MACROS_SVH

// Property that must hold at every clock edge.
`define FWH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fwh_pkg.sv
// ----------------------------------------------------------------------------
// fwh_pkg
// Sizes, status codes and transfer types of the mailbox queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fwh_pkg;

  // Ring sizes and field widths
  localparam int ITEM_DEPTH   = 16;
  localparam int WAITER_DEPTH = 8;
  localparam int WORD_WIDTH   = 32;
  localparam int READER_COUNT = 16;

  localparam int ItemPtrW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int ItemCntW = $clog2(ITEM_DEPTH + 1);
  localparam int WaitPtrW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int WaitCntW = $clog2(WAITER_DEPTH + 1);
  localparam int ReaderW  = $clog2(READER_COUNT);
  localparam int DelivW   = 32;

  // Request kinds
  localparam logic KindEnq = 1'b0;
  localparam logic KindDeq = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    StDelivered = 3'd0,
    StParked    = 3'd1,
    StStored    = 3'd2,
    StItemFull  = 3'd3,
    StWaitFull  = 3'd4
  } status_e;

  // Input transfer
  typedef struct packed {
    logic                  kind;
    logic [WORD_WIDTH-1:0] data_word;
    logic [ReaderW-1:0]    requester;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    status_e               status;
    logic [ReaderW-1:0]    target_reader;
    logic [WORD_WIDTH-1:0] out_word;
    logic [ItemCntW-1:0]   items_held;
    logic [WaitCntW-1:0]   readers_waiting;
    logic [DelivW-1:0]     delivery_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/fwh_ram.sv
// ----------------------------------------------------------------------------
// fwh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fwh_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fwh_sched.sv
// ----------------------------------------------------------------------------
// fwh_sched
// Request decode, ring pointers and counts, RAM access and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_with_waiter_handoff_macros.svh"

module fwh_sched (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request side
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire fwh_pkg::in_item_t                   in_item_i,
  // result side
  output logic                                     res_valid_o,
  input  wire logic                                res_take_i,
  output fwh_pkg::out_item_t                       res_o,
  // item ring RAM
  output logic                                     item_we_o,
  output logic            [fwh_pkg::ItemPtrW-1:0]  item_waddr_o,
  output logic            [fwh_pkg::WORD_WIDTH-1:0] item_wdata_o,
  output logic                                     item_re_o,
  output logic            [fwh_pkg::ItemPtrW-1:0]  item_raddr_o,
  input  wire logic       [fwh_pkg::WORD_WIDTH-1:0] item_rdata_i,
  // waiter ring RAM
  output logic                                     wait_we_o,
  output logic            [fwh_pkg::WaitPtrW-1:0]  wait_waddr_o,
  output logic            [fwh_pkg::ReaderW-1:0]   wait_wdata_o,
  output logic                                     wait_re_o,
  output logic            [fwh_pkg::WaitPtrW-1:0]  wait_raddr_o,
  input  wire logic       [fwh_pkg::ReaderW-1:0]   wait_rdata_i
);

  import fwh_pkg::*;

  typedef enum logic {
    Idle,
    Resp
  } state_e;

  state_e              state_q;
  logic [ItemPtrW-1:0] item_head_q, item_head_d;
  logic [ItemPtrW-1:0] item_tail_q, item_tail_d;
  logic [ItemCntW-1:0] item_cnt_q, item_cnt_d;
  logic [WaitPtrW-1:0] wait_head_q, wait_head_d;
  logic [WaitPtrW-1:0] wait_tail_q, wait_tail_d;
  logic [WaitCntW-1:0] wait_cnt_q, wait_cnt_d;
  logic [DelivW-1:0]   deliv_q, deliv_d;

  out_item_t pend_q, pend_d;
  logic      take_wait_q;
  logic      take_item_q;

  logic in_accept;
  logic is_deq;
  logic handoff, store, pop, park;

  // Decode against the current counts
  assign in_accept = in_valid_i && (state_q == Idle);
  assign is_deq    = (in_item_i.kind == KindDeq);
  assign handoff   = !is_deq && (wait_cnt_q != '0);
  assign store     = !is_deq && (wait_cnt_q == '0) && (item_cnt_q < ItemCntW'(ITEM_DEPTH));
  assign pop       = is_deq && (item_cnt_q != '0);
  assign park      = is_deq && (item_cnt_q == '0) && (wait_cnt_q < WaitCntW'(WAITER_DEPTH));

  // RAM accesses issued in the accept cycle
  assign item_we_o    = in_accept && store;
  assign item_waddr_o = item_tail_q;
  assign item_wdata_o = in_item_i.data_word;
  assign item_re_o    = in_accept && pop;
  assign item_raddr_o = item_head_q;
  assign wait_we_o    = in_accept && park;
  assign wait_waddr_o = wait_tail_q;
  assign wait_wdata_o = in_item_i.requester;
  assign wait_re_o    = in_accept && handoff;
  assign wait_raddr_o = wait_head_q;

  // Next pointers, counts and the partial result
  always_comb begin
    item_head_d = item_head_q;
    item_tail_d = item_tail_q;
    item_cnt_d  = item_cnt_q;
    wait_head_d = wait_head_q;
    wait_tail_d = wait_tail_q;
    wait_cnt_d  = wait_cnt_q;
    deliv_d     = deliv_q;
    if (handoff) begin
      wait_head_d = (wait_head_q == WaitPtrW'(WAITER_DEPTH - 1)) ? '0 : wait_head_q + 1'b1;
      wait_cnt_d  = wait_cnt_q - 1'b1;
      deliv_d     = deliv_q + 1'b1;
    end
    if (store) begin
      item_tail_d = (item_tail_q == ItemPtrW'(ITEM_DEPTH - 1)) ? '0 : item_tail_q + 1'b1;
      item_cnt_d  = item_cnt_q + 1'b1;
    end
    if (pop) begin
      item_head_d = (item_head_q == ItemPtrW'(ITEM_DEPTH - 1)) ? '0 : item_head_q + 1'b1;
      item_cnt_d  = item_cnt_q - 1'b1;
      deliv_d     = deliv_q + 1'b1;
    end
    if (park) begin
      wait_tail_d = (wait_tail_q == WaitPtrW'(WAITER_DEPTH - 1)) ? '0 : wait_tail_q + 1'b1;
      wait_cnt_d  = wait_cnt_q + 1'b1;
    end

    pend_d.target_reader   = is_deq ? in_item_i.requester : '0;
    pend_d.out_word        = handoff ? in_item_i.data_word : '0;
    pend_d.items_held      = item_cnt_d;
    pend_d.readers_waiting = wait_cnt_d;
    pend_d.delivery_count  = deliv_d;
    if (handoff || pop) begin
      pend_d.status = StDelivered;
    end else if (store) begin
      pend_d.status = StStored;
    end else if (park) begin
      pend_d.status = StParked;
    end else if (is_deq) begin
      pend_d.status = StWaitFull;
    end else begin
      pend_d.status = StItemFull;
    end
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      item_head_q <= '0;
      item_tail_q <= '0;
      item_cnt_q  <= '0;
      wait_head_q <= '0;
      wait_tail_q <= '0;
      wait_cnt_q  <= '0;
      deliv_q     <= '0;
      take_wait_q <= 1'b0;
      take_item_q <= 1'b0;
    end else begin
      case (state_q)
        Idle: begin
          if (in_accept) begin
            item_head_q <= item_head_d;
            item_tail_q <= item_tail_d;
            item_cnt_q  <= item_cnt_d;
            wait_head_q <= wait_head_d;
            wait_tail_q <= wait_tail_d;
            wait_cnt_q  <= wait_cnt_d;
            deliv_q     <= deliv_d;
            take_wait_q <= handoff;
            take_item_q <= pop;
            state_q     <= Resp;
          end
        end
        Resp: begin
          if (res_take_i) begin
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // Partial result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q <= pend_d;
    end
  end

  // Merge RAM read data into the result
  always_comb begin
    res_o = pend_q;
    if (take_wait_q) begin
      res_o.target_reader = wait_rdata_i;
    end
    if (take_item_q) begin
      res_o.out_word = item_rdata_i;
    end
  end

  assign res_valid_o = (state_q == Resp);
  assign in_stall_o  = (state_q != Idle);

  // Checks
  `FWH_ASSERT(a_rings_exclusive, (item_cnt_q == '0) || (wait_cnt_q == '0), "both rings non-empty")
  `FWH_ASSERT(a_item_cnt_bound, item_cnt_q <= ItemCntW'(ITEM_DEPTH), "item count overflow")
  `FWH_ASSERT_NEXT(a_handoff_pops, in_accept && handoff, wait_cnt_q == $past(wait_cnt_q) - 1'b1, "handoff did not pop waiter")
  `FWH_ASSERT_NEXT(a_res_hold, res_valid_o && !res_take_i, res_valid_o && $stable(res_o), "result changed before transfer")

endmodule

`default_nettype wire

>>> hw/rtl/fifo_with_waiter_handoff.sv
// A result is registered in the scheduler (payload and ring RAM read) and then loads into
// the output register; the scheduler takes no new request until that result is taken.
// A new request is taken while the previous result waits in the output register.
// Reset clears pointers, counts and the delivery counter at once; ring RAMs are not
// cleared, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// fifo_with_waiter_handoff
// Mailbox queue with blocking readers: words are handed to parked readers or
// stored, dequeues take stored words or park the reader; full rings reject.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_waiter_handoff (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire fwh_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fwh_pkg::out_item_t      out_item_o
);

  import fwh_pkg::*;

  logic                  item_we, item_re;
  logic [ItemPtrW-1:0]   item_waddr, item_raddr;
  logic [WORD_WIDTH-1:0] item_wdata, item_rdata;
  logic                  wait_we, wait_re;
  logic [WaitPtrW-1:0]   wait_waddr, wait_raddr;
  logic [ReaderW-1:0]    wait_wdata, wait_rdata;

  logic      res_valid, res_take;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_q;

  // Item ring storage
  fwh_ram #(
    .Width(WORD_WIDTH),
    .Depth(ITEM_DEPTH),
    .AddrW(ItemPtrW)
  ) u_item_ram (
    .clk_i  (clk_i),
    .we_i   (item_we),
    .waddr_i(item_waddr),
    .wdata_i(item_wdata),
    .re_i   (item_re),
    .raddr_i(item_raddr),
    .rdata_o(item_rdata)
  );

  // Waiter ring storage
  fwh_ram #(
    .Width(ReaderW),
    .Depth(WAITER_DEPTH),
    .AddrW(WaitPtrW)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (wait_we),
    .waddr_i(wait_waddr),
    .wdata_i(wait_wdata),
    .re_i   (wait_re),
    .raddr_i(wait_raddr),
    .rdata_o(wait_rdata)
  );

  fwh_sched u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .item_we_o   (item_we),
    .item_waddr_o(item_waddr),
    .item_wdata_o(item_wdata),
    .item_re_o   (item_re),
    .item_raddr_o(item_raddr),
    .item_rdata_i(item_rdata),
    .wait_we_o   (wait_we),
    .wait_waddr_o(wait_waddr),
    .wait_wdata_o(wait_wdata),
    .wait_re_o   (wait_re),
    .wait_raddr_o(wait_raddr),
    .wait_rdata_i(wait_rdata)
  );

  // Output register: loads when empty or draining
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> dv/fifo_with_waiter_handoff_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_with_waiter_handoff_checker
// Watches both channels of the mailbox queue, keeps a shadow of its rings
// and counters, predicts one result per request transfer and compares every
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module fifo_with_waiter_handoff_checker
  import fwh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        errors_o,
  output int        pending_o,
  output int        delivered_o,
  output int        parked_o,
  output int        stored_o,
  output int        item_full_o,
  output int        wait_full_o
);

  // Shadow of the mailbox state
  logic [WORD_WIDTH-1:0] word_store [ITEM_DEPTH];
  logic [ItemPtrW-1:0]   word_rd, word_wr;
  logic [ItemCntW-1:0]   words_held;
  logic [ReaderW-1:0]    parked_ids [WAITER_DEPTH];
  logic [WaitPtrW-1:0]   park_rd, park_wr;
  logic [WaitCntW-1:0]   readers_parked;
  logic [DelivW-1:0]     deliveries;

  out_item_t expected_results [$];
  out_item_t oldest;
  out_item_t predicted;
  int        results_seen;

  function automatic logic [ItemPtrW-1:0] next_word_ptr(input logic [ItemPtrW-1:0] p);
    return (p == ITEM_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WaitPtrW-1:0] next_park_ptr(input logic [WaitPtrW-1:0] p);
    return (p == WAITER_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // One request against the shadow state; returns the result it should cause
  function automatic out_item_t mailbox_step(input in_item_t req);
    out_item_t res;
    res = '0;
    if (req.kind == KindEnq) begin
      if (readers_parked != 0) begin
        // hand the word straight to the oldest parked reader
        res.status        = StDelivered;
        res.target_reader = parked_ids[park_rd];
        res.out_word      = req.data_word;
        park_rd           = next_park_ptr(park_rd);
        readers_parked    = readers_parked - 1'b1;
        deliveries        = deliveries + 1'b1;
      end else if (words_held >= ITEM_DEPTH) begin
        res.status = StItemFull;
      end else begin
        word_store[word_wr] = req.data_word;
        word_wr             = next_word_ptr(word_wr);
        words_held          = words_held + 1'b1;
        res.status          = StStored;
      end
    end else begin
      res.target_reader = req.requester;
      if (words_held != 0) begin
        res.status   = StDelivered;
        res.out_word = word_store[word_rd];
        word_rd      = next_word_ptr(word_rd);
        words_held   = words_held - 1'b1;
        deliveries   = deliveries + 1'b1;
      end else if (readers_parked >= WAITER_DEPTH) begin
        res.status = StWaitFull;
      end else begin
        parked_ids[park_wr] = req.requester;
        park_wr             = next_park_ptr(park_wr);
        readers_parked      = readers_parked + 1'b1;
        res.status          = StParked;
      end
    end
    res.items_held      = words_held;
    res.readers_waiting = readers_parked;
    res.delivery_count  = deliveries;
    return res;
  endfunction

  // Count a mismatch; only the first ten are shown
  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    errors_o++;
    if (errors_o <= 10)
      $display("[%0t] result %0d: %s mismatch, expected %0h, got %0h",
               $realtime, results_seen, field, want, got);
  endtask

  initial begin
    errors_o    = 0;
    pending_o   = 0;
    delivered_o = 0;
    parked_o    = 0;
    stored_o    = 0;
    item_full_o = 0;
    wait_full_o = 0;
    results_seen = 0;
  end

  // Compare results, then predict for a new request transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_rd        = '0;
      word_wr        = '0;
      words_held     = '0;
      park_rd        = '0;
      park_wr        = '0;
      readers_parked = '0;
      deliveries     = '0;
      expected_results.delete();
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("[%0t] result transfer with nothing expected: %p", $realtime, out_item_i);
        end else begin
          oldest = expected_results.pop_front();
          if (out_item_i.status !== oldest.status)
            note_mismatch("status", oldest.status, out_item_i.status);
          if (out_item_i.target_reader !== oldest.target_reader)
            note_mismatch("target_reader", oldest.target_reader, out_item_i.target_reader);
          if (out_item_i.out_word !== oldest.out_word)
            note_mismatch("out_word", oldest.out_word, out_item_i.out_word);
          if (out_item_i.items_held !== oldest.items_held)
            note_mismatch("items_held", oldest.items_held, out_item_i.items_held);
          if (out_item_i.readers_waiting !== oldest.readers_waiting)
            note_mismatch("readers_waiting", oldest.readers_waiting,
                          out_item_i.readers_waiting);
          if (out_item_i.delivery_count !== oldest.delivery_count)
            note_mismatch("delivery_count", oldest.delivery_count, out_item_i.delivery_count);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = mailbox_step(in_item_i);
        expected_results.push_back(predicted);
        case (predicted.status)
          StDelivered: delivered_o++;
          StParked:    parked_o++;
          StStored:    stored_o++;
          StItemFull:  item_full_o++;
          default:     wait_full_o++;
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> dv/fifo_with_waiter_handoff_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_with_waiter_handoff_tb
// Drives the mailbox queue with a directed opening (park, overflow and
// handoff of readers, store and take of words) and then random bursts of
// enqueues and dequeues under three mixes of sender and receiver idling.
// Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------

module fifo_with_waiter_handoff_tb;
  import fwh_pkg::*;

  localparam int PhaseItems = 410;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 8;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int errors, pending;
  int n_delivered, n_parked, n_stored, n_item_full, n_wait_full;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int cycles        = 0;

  fifo_with_waiter_handoff dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  fifo_with_waiter_handoff_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .delivered_o (n_delivered),
    .parked_o    (n_parked),
    .stored_o    (n_stored),
    .item_full_o (n_item_full),
    .wait_full_o (n_wait_full)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_req(input logic kind, input logic [WORD_WIDTH-1:0] word,
                                        input logic [ReaderW-1:0] who);
    in_item_t req;
    req.kind      = kind;
    req.data_word = word;
    req.requester = who;
    return req;
  endfunction

  // Random word, with the all-zero and all-one extremes now and then
  function automatic logic [WORD_WIDTH-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One request transfer, with optional idle cycles ahead of it
  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Bursts of one kind so both rings fill, drain and hand off
  task automatic run_bursts(input int n_items);
    int   sent;
    int   burst;
    logic kind;
    sent = 0;
    while (sent < n_items) begin
      kind  = 1'($urandom_range(1));
      burst = (kind == KindEnq) ? $urandom_range(1, 22) : $urandom_range(1, 12);
      repeat (burst) begin
        send_req(make_req(kind, rand_word(), ReaderW'($urandom_range(15))));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    recv_idle_pct = 48;

    // Dequeues on an empty mailbox park readers until the waiter ring overflows
    send_req(make_req(KindDeq, '1, 4'd0));
    send_req(make_req(KindDeq, '0, 4'd15));
    for (int i = 1; i < WAITER_DEPTH - 1; i++)
      send_req(make_req(KindDeq, $urandom, i[ReaderW-1:0]));
    send_req(make_req(KindDeq, $urandom, 4'd9));
    // Enqueues hand words to the parked readers, oldest first
    send_req(make_req(KindEnq, '0, 4'd3));
    send_req(make_req(KindEnq, '1, 4'd12));
    send_req(make_req(KindEnq, 32'hA5A5_A5A5, '1));
    send_req(make_req(KindEnq, 32'h5A5A_5A5A, '0));
    for (int i = 4; i < WAITER_DEPTH; i++)
      send_req(make_req(KindEnq, $urandom, ReaderW'($urandom_range(15))));
    // No reader left: words are stored, then taken by direct dequeues
    send_req(make_req(KindEnq, '1, 4'd7));
    send_req(make_req(KindEnq, 32'h0000_0001, 4'd8));
    send_req(make_req(KindDeq, '0, 4'd15));
    send_req(make_req(KindDeq, '1, 4'd0));

    run_bursts(PhaseItems);
    send_idle_pct = 48;
    recv_idle_pct = 7;
    run_bursts(PhaseItems);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_bursts(PhaseItems);
    in_valid_i <= 1'b0;

    // Drain, then give late spurious results a chance to show up
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d requests over three idle mixes: %0d deliveries, %0d parked, %0d stored",
             requests_sent, n_delivered, n_parked, n_stored);
    $display("Rejected on a full ring: %0d enqueues, %0d dequeues; %0d mismatches",
             n_item_full, n_wait_full, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> fifo_with_waiter_handoff.f
+incdir+hw/rtl
hw/rtl/fwh_pkg.sv
hw/rtl/fwh_ram.sv
hw/rtl/fwh_sched.sv
hw/rtl/fifo_with_waiter_handoff.sv
dv/fifo_with_waiter_handoff_checker.sv
dv/fifo_with_waiter_handoff_tb.sv
